// ===== sv/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg
// Widths and fixed-point constants shared by the softmax row quantizer files.
// ----------------------------------------------------------------------------
package smq_pkg;

  // field widths
  localparam int VALUE_W   = 16;
  localparam int OUT_W     = 8;
  localparam int SCALE_W   = 24;
  localparam int EXP_W     = 17;
  localparam int TOTAL_W   = 23;
  localparam int FACTOR_W  = 32;
  localparam int DIVIDEND_W = SCALE_W + FACTOR_W;

  // reset value of the output scale, 255.0 in Q16.8
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65280;

  // Q0.16 constants of the exp approximation
  localparam logic signed [18:0] K_LOG2E = 19'sd94548;
  localparam logic signed [16:0] K_LN2   = 17'sd45426;
  localparam logic signed [16:0] K_C0    = 17'sd23472;
  localparam logic signed [17:0] K_C1    = 18'sd63546;
  localparam logic signed [18:0] K_C2    = 19'sd65536;

  // largest unclamped polynomial value
  localparam logic [EXP_W-1:0] EXP_MAX = 17'd131071;

endpackage

// ===== sv/smq_stream_if.sv =====
// ----------------------------------------------------------------------------
// smq stream interfaces
// Valid/ready channels for samples, results and the scale register write.
// ----------------------------------------------------------------------------
interface smq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smq_pkg::VALUE_W-1:0]   in_value;
  logic                                 is_last;
  modport source (output valid, in_value, is_last, input ready);
  modport sink   (input valid, in_value, is_last, output ready);
endinterface

interface smq_out_if;
  logic                          valid;
  logic                          ready;
  logic [smq_pkg::OUT_W-1:0]     out_value;
  logic                          out_last;
  logic                          overflow;
  modport source (output valid, out_value, out_last, overflow, input ready);
  modport sink   (input valid, out_value, out_last, overflow, output ready);
endinterface

interface smq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smq_pkg::SCALE_W-1:0]   cfg_scale;
  modport source (output valid, cfg_scale, input ready);
  modport sink   (input valid, cfg_scale, output ready);
endinterface

// ===== sv/smq_ram.sv =====
// ----------------------------------------------------------------------------
// smq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module smq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/smq_div.sv =====
// ----------------------------------------------------------------------------
// smq_div
// Restoring divider, one quotient bit per cycle, saturating 32-bit result.
// ----------------------------------------------------------------------------
module smq_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [smq_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [smq_pkg::TOTAL_W-1:0]      divisor,
  output logic                             done,
  output logic [smq_pkg::FACTOR_W-1:0]     quotient
);

  localparam int NW = smq_pkg::DIVIDEND_W;
  localparam int DW = smq_pkg::TOTAL_W;
  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic          ge;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_r[DW-1:0], num_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  // zero divisor gives zero, large quotient saturates
  always_comb begin
    if (den_r == '0) begin
      quotient = '0;
    end else if (|quo_r[NW-1:smq_pkg::FACTOR_W]) begin
      quotient = '1;
    end else begin
      quotient = quo_r[smq_pkg::FACTOR_W-1:0];
    end
  end

  assign done = done_r;

  // the divider completes exactly one quotient per start
  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("divider not busy after start");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

// ===== sv/softmax_row_u8_quantizer.sv =====
// ----------------------------------------------------------------------------
// softmax_row_u8_quantizer
// Row softmax with unsigned byte output, polynomial exp, fixed point.
// ----------------------------------------------------------------------------
// Samples of a row are taken one per cycle into a sample RAM while the row
// maximum is tracked; samples past ROW_MAX are dropped and flag overflow.
// After the marked sample the block stops taking input: an exp pass streams
// the row through a five-stage pipeline into an exp RAM, a restoring
// divider forms the scale factor one bit a cycle, and the emit pass reads
// each exp, multiplies and rounds in its read, multiply and round states,
// holding in the round state while the output register is still full.
// The next row is taken as soon as the last result sits in the
// output register. The scale register may be written at any time the
// block is idle.
// ----------------------------------------------------------------------------
module softmax_row_u8_quantizer #(
  parameter int ROW_MAX = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  smq_in_if.sink    in_ch,
  smq_out_if.source out_ch,
  smq_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = (ROW_MAX < 2) ? 2 : ROW_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(ROW_MAX + 1);
  localparam int EW    = smq_pkg::EXP_W;

  typedef enum logic [2:0] {
    S_LOAD, S_EXP, S_DIV_GO, S_DIV_WAIT, S_E_RD, S_E_MUL, S_E_RND
  } state_t;

  state_t state_r;

  logic [smq_pkg::SCALE_W-1:0]         scale_r;
  logic signed [smq_pkg::VALUE_W-1:0]  max_r;
  logic [CW-1:0]                       cnt_r;
  logic                                ovf_r;
  logic [smq_pkg::TOTAL_W-1:0]         total_r;
  logic [CW-1:0]                       rd_idx_r;
  logic [CW-1:0]                       wr_cnt_r;
  logic [CW-1:0]                       e_idx_r;
  logic [smq_pkg::FACTOR_W-1:0]        factor_r;
  logic                                out_valid_r;
  logic [smq_pkg::OUT_W-1:0]           out_value_r;
  logic                                out_last_r;
  logic                                out_ovf_r;

  // pipeline valids and addresses
  logic          v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] a0_r, a1_r, a2_r, a3_r, a4_r;

  logic in_xfer, keep, issue, last_wr, emit_load, emit_last;

  // ram ports
  logic signed [smq_pkg::VALUE_W-1:0] smp_rdata;
  logic [EW-1:0]                      exp_rdata;
  logic [EW-1:0]                      exp_w;

  // divider
  logic                          div_start, div_done;
  logic [smq_pkg::FACTOR_W-1:0]  div_q;

  assign in_ch.ready  = (state_r == S_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign keep         = (cnt_r < CW'(ROW_MAX));
  assign issue        = (state_r == S_EXP) && (rd_idx_r < cnt_r);
  assign last_wr      = v4_r && ((wr_cnt_r + 1'b1) == cnt_r);
  assign div_start    = (state_r == S_DIV_GO);
  assign emit_load    = (state_r == S_E_RND) && (!out_valid_r || out_ch.ready);
  assign emit_last    = ((e_idx_r + 1'b1) == cnt_r);

  smq_ram #(.WIDTH(smq_pkg::VALUE_W), .DEPTH(DEPTH)) u_smp_ram (
    .clk   (clk),
    .we    (in_xfer && keep),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_ch.in_value),
    .re    (issue),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (smp_rdata)
  );

  smq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_exp_ram (
    .clk   (clk),
    .we    (v4_r),
    .waddr (a4_r),
    .wdata (exp_w),
    .re    (state_r == S_E_RD),
    .raddr (e_idx_r[AW-1:0]),
    .rdata (exp_rdata)
  );

  smq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({scale_r, {smq_pkg::FACTOR_W{1'b0}}}),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // exp pipeline datapath
  logic signed [16:0] d0;
  logic signed [16:0] d1_r;
  logic signed [34:0] t1_r;
  logic [34:0]        neg_t;
  logic [10:0]        nz2;
  logic [10:0]        nz2_r, nz3_r, nz4_r;
  logic signed [25:0] q2_r, q3_r;
  logic signed [41:0] m3_r;
  logic signed [41:0] y1_w;
  logic signed [52:0] m4_r;
  logic signed [52:0] y2_w;
  logic [EW-1:0]      y_cl;
  logic [48:0]        prod_r;
  logic [8:0]         ip;
  logic [39:0]        fr;
  logic               rnd_up;
  logic [9:0]         ipr;
  logic [smq_pkg::OUT_W-1:0] out_byte;

  // difference to the row maximum
  assign d0    = 17'(smp_rdata) - 17'(max_r);
  // z = -floor(-t / 2^24), kept as its magnitude
  assign neg_t = 35'(-t1_r);
  assign nz2   = neg_t[34:24];
  assign y1_w  = (m3_r >>> 16) + 42'(smq_pkg::K_C1);
  assign y2_w  = (m4_r >>> 16) + 53'(smq_pkg::K_C2);

  // clamp polynomial and apply the power of two
  always_comb begin
    if (y2_w < 0) begin
      y_cl = '0;
    end else if (y2_w > 53'(smq_pkg::EXP_MAX)) begin
      y_cl = smq_pkg::EXP_MAX;
    end else begin
      y_cl = y2_w[EW-1:0];
    end
    exp_w = (nz4_r >= 11'd32) ? '0 : (y_cl >> nz4_r[4:0]);
  end

  always_ff @(posedge clk) begin
    d1_r  <= d0;
    t1_r  <= d0 * smq_pkg::K_LOG2E;
    nz2_r <= nz2;
    q2_r  <= (26'(d1_r) <<< 8) + $signed({1'b0, nz2}) * smq_pkg::K_LN2;
    nz3_r <= nz2_r;
    q3_r  <= q2_r;
    m3_r  <= smq_pkg::K_C0 * q2_r;
    nz4_r <= nz3_r;
    m4_r  <= $signed(y1_w[26:0]) * q3_r;
    prod_r <= exp_rdata * factor_r;
  end

  // round half to even at 2^40, clamp to a byte
  assign ip       = prod_r[48:40];
  assign fr       = prod_r[39:0];
  assign rnd_up   = fr[39] && ((|fr[38:0]) || ip[0]);
  assign ipr      = {1'b0, ip} + 10'(rnd_up);
  assign out_byte = (ipr > 10'd255) ? 8'd255 : ipr[7:0];

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      scale_r     <= smq_pkg::SCALE_RESET;
      max_r       <= 16'sh8000;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      rd_idx_r    <= '0;
      wr_cnt_r    <= '0;
      e_idx_r     <= '0;
      factor_r    <= '0;
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      out_last_r  <= 1'b0;
      out_ovf_r   <= 1'b0;
      {v0_r, v1_r, v2_r, v3_r, v4_r} <= '0;
      {a0_r, a1_r, a2_r, a3_r, a4_r} <= '0;
    end else begin
      if (cfg_ch.valid) begin
        scale_r <= cfg_ch.cfg_scale;
      end
      if (out_valid_r && out_ch.ready && !emit_load) begin
        out_valid_r <= 1'b0;
      end

      // pipeline shift
      v0_r <= issue;
      a0_r <= rd_idx_r[AW-1:0];
      {v1_r, v2_r, v3_r, v4_r} <= {v0_r, v1_r, v2_r, v3_r};
      {a1_r, a2_r, a3_r, a4_r} <= {a0_r, a1_r, a2_r, a3_r};

      if (v4_r) begin
        total_r  <= total_r + smq_pkg::TOTAL_W'(exp_w);
        wr_cnt_r <= wr_cnt_r + 1'b1;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (keep) begin
              cnt_r <= cnt_r + 1'b1;
              if (in_ch.in_value > max_r) begin
                max_r <= in_ch.in_value;
              end
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_ch.is_last) begin
              rd_idx_r <= '0;
              wr_cnt_r <= '0;
              total_r  <= '0;
              state_r  <= S_EXP;
            end
          end
        end
        S_EXP: begin
          if (issue) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          if (last_wr) begin
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            factor_r <= div_q;
            e_idx_r  <= '0;
            state_r  <= S_E_RD;
          end
        end
        S_E_RD: begin
          state_r <= S_E_MUL;
        end
        S_E_MUL: begin
          state_r <= S_E_RND;
        end
        S_E_RND: begin
          if (emit_load) begin
            out_valid_r <= 1'b1;
            out_value_r <= out_byte;
            out_last_r  <= emit_last;
            out_ovf_r   <= ovf_r;
            if (emit_last) begin
              cnt_r   <= '0;
              max_r   <= 16'sh8000;
              ovf_r   <= 1'b0;
              total_r <= '0;
              state_r <= S_LOAD;
            end else begin
              e_idx_r <= e_idx_r + 1'b1;
              state_r <= S_E_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.overflow  = out_ovf_r;

  // sanity checks on sequencing
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(ROW_MAX))
    else $error("row count beyond row limit");
  assert property (@(posedge clk) disable iff (!rst_n) v4_r |-> (wr_cnt_r < cnt_r))
    else $error("exp write past row end");
  assert property (@(posedge clk) disable iff (!rst_n)
      div_done |-> (state_r == S_DIV_WAIT))
    else $error("divider result outside wait state");
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_E_RND) && emit_load |=> out_valid_r)
    else $error("result transfer lost");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the softmax row quantizer against a fixed-point predictor of its own.
// A directed table (extremes, equal rows, very small exps) runs first, then
// random rows under several output scales, including an overflowing row. Both
// sides idle at random, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ROW_LIMIT  = 64;
  localparam int WATCH_MAX  = 6000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [smq_pkg::OUT_W-1:0] value;
    logic                      last;
    logic                      ovf;
  } prob_t;

  typedef struct {
    int   sample;
    bit   last;
    bit   typed;
    int   want;
  } row_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smq_in_if  in_ch ();
  smq_out_if out_ch ();
  smq_cfg_if cfg_ch ();

  softmax_row_u8_quantizer #(.ROW_MAX(ROW_LIMIT)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [smq_pkg::SCALE_W-1:0] scale_q = smq_pkg::SCALE_RESET;
  int                 kept_q[$];
  int                 peak;
  bit                 dropped;
  prob_t              prob_q[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exp of a non-positive Q8.8 difference, Q0.16 result
  function automatic longint unsigned poly_exp(longint d);
    longint t, z, q, y;
    t = d * longint'(smq_pkg::K_LOG2E);
    z = -((-t) >>> 24);
    q = d * 256 - z * longint'(smq_pkg::K_LN2);
    y = ((longint'(smq_pkg::K_C0) * q) >>> 16) + longint'(smq_pkg::K_C1);
    y = ((y * q) >>> 16) + longint'(smq_pkg::K_C2);
    if (y < 0) y = 0;
    if (y > longint'(smq_pkg::EXP_MAX)) y = longint'(smq_pkg::EXP_MAX);
    if (-z >= 32) return 0;
    return longint'(unsigned'(y)) >> (-z);
  endfunction

  function automatic void row_reset();
    kept_q.delete();
    peak = -32768;
    dropped = 1'b0;
  endfunction

  // take one accepted sample; on the row end, queue the expected bytes
  function automatic void take_sample(int x, bit last);
    longint unsigned exps[$];
    longint unsigned total, factor, p, ip, fr;
    prob_t r;
    if (kept_q.size() < ROW_LIMIT) begin
      kept_q.push_back(x);
      if (x > peak) peak = x;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    total = 0;
    foreach (kept_q[i]) begin
      exps.push_back(poly_exp(longint'(kept_q[i]) - longint'(peak)));
      total += exps[i];
    end
    total &= 64'h7FFFFF;
    if (total == 0) factor = 0;
    else begin
      factor = (longint'(scale_q) << 32) / total;
      if (factor > 64'hFFFF_FFFF) factor = 64'hFFFF_FFFF;
    end
    foreach (exps[i]) begin
      p  = exps[i] * factor;
      ip = p >> 40;
      fr = p & ((64'd1 << 40) - 1);
      if (fr > (64'd1 << 39) || (fr == (64'd1 << 39) && ip[0])) ip++;
      if (ip > 255) ip = 255;
      r.value = ip[7:0];
      r.last  = (i == exps.size() - 1);
      r.ovf   = dropped;
      prob_q.push_back(r);
    end
    row_reset();
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one sample transfer, then a random gap
  task automatic send_sample(int x, bit last);
    int gap;
    in_ch.valid    = 1'b1;
    in_ch.in_value = x[15:0];
    in_ch.is_last  = last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    take_sample(x, last);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (prob_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_scale(logic [smq_pkg::SCALE_W-1:0] s);
    wait_drained();
    cfg_ch.valid     = 1'b1;
    cfg_ch.cfg_scale = s;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    scale_q = s;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // random row: mostly short, values spread or clustered near a base
  task automatic random_row(int len);
    int base, x;
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0:       x = $urandom_range(0, 65535) - 32768;
        1:       x = $urandom_range(0, 1) ? 32767 : -32768;
        default: x = base + $urandom_range(0, 1023) - 512;
      endcase
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      send_sample(x, i == len - 1);
    end
  endtask

  // directed rows, expected bytes typed where they are obvious
  row_entry_t directed[] = '{
    '{32767, 1, 1, 255},
    '{-32768, 1, 1, 255},
    '{-32768, 0, 1, 0}, '{32767, 1, 1, 255},
    '{0, 0, 1, 128}, '{0, 1, 1, 128},
    '{256, 0, 1, 64}, '{256, 0, 1, 64}, '{256, 0, 1, 64}, '{256, 1, 1, 64},
    '{0, 0, 0, 0}, '{-256, 0, 0, 0}, '{-512, 1, 0, 0},
    '{100, 0, 0, 0}, '{-5, 0, 0, 0}, '{7, 0, 0, 0}, '{-1, 1, 0, 0},
    '{-300, 0, 0, 0}, '{-32767, 0, 0, 0}, '{-299, 1, 0, 0},
    '{1, 1, 0, 0}
  };

  // stimulus
  initial begin
    int row_len, phase_items, base_idx;
    logic [smq_pkg::SCALE_W-1:0] scales[6];
    row_entry_t row_buf[$];
    in_ch.valid = 1'b0;
    in_ch.in_value = '0;
    in_ch.is_last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.cfg_scale = '0;
    row_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the reset scale
    foreach (directed[i]) begin
      row_buf.push_back(directed[i]);
      send_sample(directed[i].sample, directed[i].last);
      if (directed[i].last) begin
        base_idx = prob_q.size() - row_buf.size();
        foreach (row_buf[j])
          if (row_buf[j].typed)
            prob_q[base_idx + j].value = row_buf[j].want[smq_pkg::OUT_W-1:0];
        row_buf.delete();
      end
    end

    // scale extremes: zero scale gives zeros, full scale saturates the factor
    write_scale('0);
    send_sample(5, 0); send_sample(-7, 1);
    write_scale(24'hFFFFFF);
    send_sample(-32768, 1);

    // random phases over several scales
    scales = '{24'hFFFFFF, 24'd0, 24'd256, smq_pkg::SCALE_RESET, 24'd1, 24'd0};
    scales[1] = smq_pkg::SCALE_W'($urandom_range(0, 24'hFFFFFF));
    scales[5] = smq_pkg::SCALE_W'($urandom_range(24'h100, 24'h3FFFF));
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(scales[ph]);
      no_idle = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      phase_items = 0;
      if (ph == 2) begin
        row_len = $urandom_range(65, 66);
        random_row(row_len);
      end
      while (phase_items < 5) begin
        row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                              : $urandom_range(1, 8);
        random_row(row_len);
        phase_items += row_len;
      end
    end

    in_ch.valid = 1'b0;
    while (prob_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // receiver: random ready, one long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready = no_idle ? 1'b1 : ($urandom_range(0, 9) < 7);
      if (!no_idle && $urandom_range(0, 49) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    prob_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (prob_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d last %0b overflow %0b",
                   out_ch.out_value, out_ch.out_last, out_ch.overflow);
      end else begin
        e = prob_q.pop_front();
        if (out_ch.out_value !== e.value || out_ch.out_last !== e.last ||
            out_ch.overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     e.value, e.last, e.ovf,
                     out_ch.out_value, out_ch.out_last, out_ch.overflow);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/smq_pkg.sv
sv/smq_stream_if.sv
sv/smq_ram.sv
sv/smq_div.sv
sv/softmax_row_u8_quantizer.sv
bench/testbench.sv
